// ===== rtl/bmmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmmc_pkg
// Shared constants and types for the bipartite matching and cover block.
// ----------------------------------------------------------------------------
package bmmc_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 8192;

    localparam int EDGE_W    = 10;
    localparam int COUNT_W   = 11;
    localparam int KIND_W    = 2;
    localparam int WIDX_W    = 4;
    localparam int BITS_W    = 64;
    localparam int MSIZE_W   = 11;
    localparam int CFG_IDX_W = 1;
    localparam int GROUP     = 64;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT = 1'b1;

    localparam logic [KIND_W-1:0] KIND_LEFT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RIGHT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

    typedef struct packed {
        logic [EDGE_W-1:0] edge_left;
        logic [EDGE_W-1:0] edge_right;
        logic              last_edge;
    } t_edge;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [WIDX_W-1:0]  word_index;
        logic [BITS_W-1:0]  cover_bits;
        logic [MSIZE_W-1:0] matching_size;
        logic               edges_dropped;
        logic               last;
    } t_result;

endpackage

// ===== rtl/bmmc_edge_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmmc_edge_if
// Edge channel: valid/ready with one bipartite edge per transfer.
// ----------------------------------------------------------------------------
interface bmmc_edge_if;
    logic                         valid;
    logic                         ready;
    logic [bmmc_pkg::EDGE_W-1:0]  edge_left;
    logic [bmmc_pkg::EDGE_W-1:0]  edge_right;
    logic                         last_edge;

    modport source (output valid, output edge_left, output edge_right,
                    output last_edge, input ready);
    modport sink   (input valid, input edge_left, input edge_right,
                    input last_edge, output ready);
endinterface

// ===== rtl/bmmc_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmmc_result_if
// Result channel: valid/ready carrying cover words and the summary.
// ----------------------------------------------------------------------------
interface bmmc_result_if;
    logic                          valid;
    logic                          ready;
    logic [bmmc_pkg::KIND_W-1:0]   kind;
    logic [bmmc_pkg::WIDX_W-1:0]   word_index;
    logic [bmmc_pkg::BITS_W-1:0]   cover_bits;
    logic [bmmc_pkg::MSIZE_W-1:0]  matching_size;
    logic                          edges_dropped;
    logic                          last;

    modport source (output valid, output kind, output word_index, output cover_bits,
                    output matching_size, output edges_dropped, output last,
                    input ready);
    modport sink   (input valid, input kind, input word_index, input cover_bits,
                    input matching_size, input edges_dropped, input last,
                    output ready);
endinterface

// ===== rtl/bmmc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmmc_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bmmc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = bmmc_pkg::MAX_VERTICES,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bmmc_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmmc_engine
// Store clear, edge store, Hopcroft-Karp sequencer, cover BFS, cover word and
// summary readout, all working on single-port-read RAMs.
// ----------------------------------------------------------------------------
module bmmc_engine #(
    parameter int V = bmmc_pkg::MAX_VERTICES,
    parameter int E = bmmc_pkg::MAX_EDGES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [bmmc_pkg::COUNT_W-1:0] i_nl,
    input  logic [bmmc_pkg::COUNT_W-1:0] i_nr,
    input  bmmc_pkg::t_edge              i_edge,
    input  logic                         i_edge_valid,
    output logic                         o_edge_ready,
    output bmmc_pkg::t_result            o_res,
    output logic                         o_res_valid,
    input  logic                         i_res_ready
);

    localparam int CW = bmmc_pkg::COUNT_W;
    localparam int BW = CW + 1;
    localparam int VW = $clog2(V);
    localparam int VX = VW + 1;
    localparam int EW = $clog2(E);
    localparam int EX = EW + 1;
    localparam int GN = (V + bmmc_pkg::GROUP - 1) / bmmc_pkg::GROUP;
    localparam int GW = (GN > 1) ? $clog2(GN) : 1;
    localparam int GX = GW + 1;
    localparam int SW = VW + EX;
    localparam int MW = bmmc_pkg::MSIZE_W;
    localparam int DW = bmmc_pkg::BITS_W;

    localparam logic [VX-1:0] FAR = {VX{1'b1}};
    localparam logic [VX-1:0] UNM = VX'(V);
    localparam logic [EX-1:0] NIL = EX'(E);

    typedef enum logic [36:0] {
        S_CLR    = 37'd1 << 0,
        S_IDLE   = 37'd1 << 1,
        S_ST     = 37'd1 << 2,
        S_LB_I0  = 37'd1 << 3,
        S_LB_I1  = 37'd1 << 4,
        S_LB_Q   = 37'd1 << 5,
        S_LB_U   = 37'd1 << 6,
        S_LB_H   = 37'd1 << 7,
        S_LB_E   = 37'd1 << 8,
        S_LB_T   = 37'd1 << 9,
        S_LB_W   = 37'd1 << 10,
        S_LB_L   = 37'd1 << 11,
        S_AG_I0  = 37'd1 << 12,
        S_AG_I1  = 37'd1 << 13,
        S_AG_R   = 37'd1 << 14,
        S_AG_S   = 37'd1 << 15,
        S_AG_POP = 37'd1 << 16,
        S_AG_PP2 = 37'd1 << 17,
        S_AG_T   = 37'd1 << 18,
        S_AG_W   = 37'd1 << 19,
        S_AG_L   = 37'd1 << 20,
        S_AG_F0  = 37'd1 << 21,
        S_AG_F1  = 37'd1 << 22,
        S_AG_F2  = 37'd1 << 23,
        S_AG_F3  = 37'd1 << 24,
        S_CV_I0  = 37'd1 << 25,
        S_CV_I1  = 37'd1 << 26,
        S_CV_Q   = 37'd1 << 27,
        S_CV_U   = 37'd1 << 28,
        S_CV_H   = 37'd1 << 29,
        S_CV_E   = 37'd1 << 30,
        S_CV_T   = 37'd1 << 31,
        S_CV_S   = 37'd1 << 32,
        S_CV_L   = 37'd1 << 33,
        S_OW_R   = 37'd1 << 34,
        S_OW_P   = 37'd1 << 35,
        S_OS     = 37'd1 << 36
    } t_state;

    t_state r_state, n_state;
    logic [VX-1:0] r_u, n_u, r_qh, n_qh, r_qt, n_qt, r_sp, n_sp, r_k, n_k;
    logic [VX-1:0] r_lu, n_lu, r_pu, n_pu, r_c, n_c;
    logic [VW-1:0] r_cu, n_cu, r_v, n_v, r_w, n_w, r_el, n_el;
    logic [EX-1:0] r_e, n_e, r_lnk, n_lnk, r_total, n_total;
    logic [EW-1:0] r_id, n_id;
    logic [MW-1:0] r_msize, n_msize;
    logic [GX-1:0] r_g, n_g;
    logic          r_found, n_found, r_drop, n_drop, r_last, n_last, r_side, n_side;

    // RAM ports
    logic          hd_we, tl_we, tg_we, lk_we, pl_we, pr_we, ly_we, q_we, st_we;
    logic          sl_we, sr_we;
    logic [VW-1:0] hd_wa, hd_ra, tl_wa, tl_ra, pl_wa, pl_ra, pr_wa, pr_ra;
    logic [VW-1:0] ly_wa, ly_ra, q_wa, q_ra, st_wa, st_ra;
    logic [EW-1:0] tg_wa, tg_ra, lk_wa, lk_ra;
    logic [GW-1:0] sl_wa, sl_ra, sr_wa, sr_ra;
    logic [EX-1:0] hd_wd, hd_rd, lk_wd, lk_rd;
    logic [EW-1:0] tl_wd, tl_rd;
    logic [VW-1:0] tg_wd, tg_rd, q_wd, q_rd;
    logic [VX-1:0] pl_wd, pl_rd, pr_wd, pr_rd, ly_wd, ly_rd;
    logic [SW-1:0] st_wd, st_rd;
    logic [DW-1:0] sl_wd, sl_rd, sr_wd, sr_rd;

    bmmc_ram #(.WIDTH(EX), .DEPTH(V)) u_head (.i_clk, .i_we(hd_we), .i_waddr(hd_wa),
        .i_wdata(hd_wd), .i_raddr(hd_ra), .o_rdata(hd_rd));
    bmmc_ram #(.WIDTH(EW), .DEPTH(V)) u_tail (.i_clk, .i_we(tl_we), .i_waddr(tl_wa),
        .i_wdata(tl_wd), .i_raddr(tl_ra), .o_rdata(tl_rd));
    bmmc_ram #(.WIDTH(VW), .DEPTH(E)) u_target (.i_clk, .i_we(tg_we), .i_waddr(tg_wa),
        .i_wdata(tg_wd), .i_raddr(tg_ra), .o_rdata(tg_rd));
    bmmc_ram #(.WIDTH(EX), .DEPTH(E)) u_link (.i_clk, .i_we(lk_we), .i_waddr(lk_wa),
        .i_wdata(lk_wd), .i_raddr(lk_ra), .o_rdata(lk_rd));
    bmmc_ram #(.WIDTH(VX), .DEPTH(V)) u_pleft (.i_clk, .i_we(pl_we), .i_waddr(pl_wa),
        .i_wdata(pl_wd), .i_raddr(pl_ra), .o_rdata(pl_rd));
    bmmc_ram #(.WIDTH(VX), .DEPTH(V)) u_pright (.i_clk, .i_we(pr_we), .i_waddr(pr_wa),
        .i_wdata(pr_wd), .i_raddr(pr_ra), .o_rdata(pr_rd));
    bmmc_ram #(.WIDTH(VX), .DEPTH(V)) u_layer (.i_clk, .i_we(ly_we), .i_waddr(ly_wa),
        .i_wdata(ly_wd), .i_raddr(ly_ra), .o_rdata(ly_rd));
    bmmc_ram #(.WIDTH(VW), .DEPTH(V)) u_queue (.i_clk, .i_we(q_we), .i_waddr(q_wa),
        .i_wdata(q_wd), .i_raddr(q_ra), .o_rdata(q_rd));
    bmmc_ram #(.WIDTH(SW), .DEPTH(V)) u_stack (.i_clk, .i_we(st_we), .i_waddr(st_wa),
        .i_wdata(st_wd), .i_raddr(st_ra), .o_rdata(st_rd));
    bmmc_ram #(.WIDTH(DW), .DEPTH(GN)) u_seenl (.i_clk, .i_we(sl_we), .i_waddr(sl_wa),
        .i_wdata(sl_wd), .i_raddr(sl_ra), .o_rdata(sl_rd));
    bmmc_ram #(.WIDTH(DW), .DEPTH(GN)) u_seenr (.i_clk, .i_we(sr_we), .i_waddr(sr_wa),
        .i_wdata(sr_wd), .i_raddr(sr_ra), .o_rdata(sr_rd));

    // cover word helpers
    logic [CW-1:0] w_cnt;
    logic [BW-1:0] w_base, w_rem;
    logic          w_last_word, w_last_root, w_drop;
    logic [DW-1:0] w_mask;

    always_comb begin
        w_cnt       = r_side ? i_nr : i_nl;
        w_base      = BW'({r_g, 6'b0});
        w_rem       = BW'(w_cnt) - w_base;
        w_last_word = (w_base + BW'(bmmc_pkg::GROUP)) >= BW'(w_cnt);
        w_mask      = (w_rem >= BW'(bmmc_pkg::GROUP)) ? {DW{1'b1}}
                                                      : ((DW'(1) << w_rem[5:0]) - DW'(1));
        w_last_root = (CW'(r_u) + CW'(1)) == i_nl;
        w_drop      = (CW'(i_edge.edge_left) >= i_nl) || (CW'(i_edge.edge_right) >= i_nr)
                      || (r_total >= NIL);
    end

    always_comb begin
        n_state = r_state;
        n_u = r_u;  n_qh = r_qh;  n_qt = r_qt;  n_sp = r_sp;  n_k = r_k;
        n_lu = r_lu;  n_pu = r_pu;  n_c = r_c;  n_cu = r_cu;  n_v = r_v;  n_w = r_w;
        n_el = r_el;  n_e = r_e;  n_lnk = r_lnk;  n_total = r_total;  n_id = r_id;
        n_msize = r_msize;  n_g = r_g;  n_found = r_found;  n_drop = r_drop;
        n_last = r_last;  n_side = r_side;

        hd_we = 1'b0;  hd_wa = '0;  hd_wd = '0;  hd_ra = '0;
        tl_we = 1'b0;  tl_wa = '0;  tl_wd = '0;  tl_ra = '0;
        tg_we = 1'b0;  tg_wa = '0;  tg_wd = '0;  tg_ra = '0;
        lk_we = 1'b0;  lk_wa = '0;  lk_wd = '0;  lk_ra = '0;
        pl_we = 1'b0;  pl_wa = '0;  pl_wd = '0;  pl_ra = '0;
        pr_we = 1'b0;  pr_wa = '0;  pr_wd = '0;  pr_ra = '0;
        ly_we = 1'b0;  ly_wa = '0;  ly_wd = '0;  ly_ra = '0;
        q_we  = 1'b0;  q_wa  = '0;  q_wd  = '0;  q_ra  = '0;
        st_we = 1'b0;  st_wa = '0;  st_wd = '0;  st_ra = '0;
        sl_we = 1'b0;  sl_wa = '0;  sl_wd = '0;  sl_ra = '0;
        sr_we = 1'b0;  sr_wa = '0;  sr_wd = '0;  sr_ra = '0;

        o_edge_ready = 1'b0;
        o_res_valid  = 1'b0;
        o_res        = '0;

        unique case (r_state)
            S_CLR: begin
                hd_we = 1'b1;  hd_wa = r_c[VW-1:0];  hd_wd = NIL;
                pl_we = 1'b1;  pl_wa = r_c[VW-1:0];  pl_wd = UNM;
                pr_we = 1'b1;  pr_wa = r_c[VW-1:0];  pr_wd = UNM;
                sl_we = r_c < VX'(GN);  sl_wa = GW'(r_c);  sl_wd = '0;
                sr_we = r_c < VX'(GN);  sr_wa = GW'(r_c);  sr_wd = '0;
                n_c = r_c + VX'(1);
                if (r_c == VX'(V - 1)) begin
                    n_total = '0;
                    n_drop  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_edge_ready = 1'b1;
                hd_ra = VW'(i_edge.edge_left);
                tl_ra = VW'(i_edge.edge_left);
                if (i_edge_valid) begin
                    n_last  = i_edge.last_edge;
                    n_msize = '0;
                    if (w_drop) begin
                        n_drop = 1'b1;
                        if (i_edge.last_edge) begin
                            n_u = '0;  n_qh = '0;  n_qt = '0;  n_found = 1'b0;
                            n_state = S_LB_I0;
                        end
                    end else begin
                        tg_we = 1'b1;  tg_wa = r_total[EW-1:0];  tg_wd = VW'(i_edge.edge_right);
                        lk_we = 1'b1;  lk_wa = r_total[EW-1:0];  lk_wd = NIL;
                        n_el    = VW'(i_edge.edge_left);
                        n_id    = r_total[EW-1:0];
                        n_total = r_total + EX'(1);
                        n_state = S_ST;
                    end
                end
            end
            S_ST: begin
                if (hd_rd >= NIL) begin
                    hd_we = 1'b1;  hd_wa = r_el;  hd_wd = EX'(r_id);
                end else begin
                    lk_we = 1'b1;  lk_wa = tl_rd;  lk_wd = EX'(r_id);
                end
                tl_we = 1'b1;  tl_wa = r_el;  tl_wd = r_id;
                if (r_last) begin
                    n_u = '0;  n_qh = '0;  n_qt = '0;  n_found = 1'b0;
                    n_state = S_LB_I0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            // layered BFS
            S_LB_I0: begin
                pl_ra = r_u[VW-1:0];
                n_state = S_LB_I1;
            end
            S_LB_I1: begin
                ly_we = 1'b1;  ly_wa = r_u[VW-1:0];
                if (pl_rd == UNM) begin
                    ly_wd = '0;
                    q_we = 1'b1;  q_wa = r_qt[VW-1:0];  q_wd = r_u[VW-1:0];
                    n_qt = r_qt + VX'(1);
                end else begin
                    ly_wd = FAR;
                end
                n_u = r_u + VX'(1);
                n_state = w_last_root ? S_LB_Q : S_LB_I0;
            end
            S_LB_Q: begin
                q_ra = r_qh[VW-1:0];
                if (r_qh < r_qt) begin
                    n_qh = r_qh + VX'(1);
                    n_state = S_LB_U;
                end else if (r_found) begin
                    n_u = '0;
                    n_state = S_AG_I0;
                end else begin
                    n_u = '0;  n_qh = '0;  n_qt = '0;
                    n_state = S_CV_I0;
                end
            end
            S_LB_U: begin
                hd_ra = q_rd;  ly_ra = q_rd;
                n_state = S_LB_H;
            end
            S_LB_H: begin
                n_e = hd_rd;  n_lu = ly_rd;
                n_state = S_LB_E;
            end
            S_LB_E: begin
                tg_ra = r_e[EW-1:0];  lk_ra = r_e[EW-1:0];
                n_state = (r_e >= NIL) ? S_LB_Q : S_LB_T;
            end
            S_LB_T: begin
                n_e = lk_rd;  pr_ra = tg_rd;
                n_state = (CW'(tg_rd) >= i_nr) ? S_LB_E : S_LB_W;
            end
            S_LB_W: begin
                ly_ra = pr_rd[VW-1:0];  n_w = pr_rd[VW-1:0];
                if (pr_rd == UNM) begin
                    n_found = 1'b1;
                    n_state = S_LB_E;
                end else begin
                    n_state = (CW'(pr_rd) < i_nl) ? S_LB_L : S_LB_E;
                end
            end
            S_LB_L: begin
                if (ly_rd == FAR && r_qt < VX'(V)) begin
                    ly_we = 1'b1;  ly_wa = r_w;  ly_wd = r_lu + VX'(1);
                    q_we = 1'b1;  q_wa = r_qt[VW-1:0];  q_wd = r_w;
                    n_qt = r_qt + VX'(1);
                end
                n_state = S_LB_E;
            end
            // augmentation
            S_AG_I0: begin
                pl_ra = r_u[VW-1:0];
                n_state = S_AG_I1;
            end
            S_AG_I1: begin
                hd_ra = r_u[VW-1:0];  ly_ra = r_u[VW-1:0];
                if (pl_rd == UNM) begin
                    n_state = S_AG_R;
                end else if (w_last_root) begin
                    n_u = '0;  n_qh = '0;  n_qt = '0;  n_found = 1'b0;
                    n_state = S_LB_I0;
                end else begin
                    n_u = r_u + VX'(1);
                    n_state = S_AG_I0;
                end
            end
            S_AG_R: begin
                n_cu = r_u[VW-1:0];  n_e = hd_rd;  n_lu = ly_rd;  n_sp = VX'(1);
                n_state = S_AG_S;
            end
            S_AG_S: begin
                tg_ra = r_e[EW-1:0];  lk_ra = r_e[EW-1:0];
                st_ra = VW'(r_sp - VX'(2));
                if (r_e >= NIL) begin
                    ly_we = 1'b1;  ly_wa = r_cu;  ly_wd = FAR;
                    n_sp = r_sp - VX'(1);
                    if (r_sp == VX'(1)) begin
                        if (w_last_root) begin
                            n_u = '0;  n_qh = '0;  n_qt = '0;  n_found = 1'b0;
                            n_state = S_LB_I0;
                        end else begin
                            n_u = r_u + VX'(1);
                            n_state = S_AG_I0;
                        end
                    end else begin
                        n_state = S_AG_POP;
                    end
                end else begin
                    n_state = S_AG_T;
                end
            end
            S_AG_POP: begin
                n_cu  = st_rd[SW-1:EX];
                lk_ra = st_rd[EW-1:0];
                ly_ra = st_rd[SW-1:EX];
                n_state = S_AG_PP2;
            end
            S_AG_PP2: begin
                n_e = lk_rd;  n_lu = ly_rd;
                n_state = S_AG_S;
            end
            S_AG_T: begin
                n_v = tg_rd;  n_lnk = lk_rd;  pr_ra = tg_rd;
                if (CW'(tg_rd) >= i_nr) begin
                    n_e = lk_rd;
                    n_state = S_AG_S;
                end else begin
                    n_state = S_AG_W;
                end
            end
            S_AG_W: begin
                n_w = pr_rd[VW-1:0];
                ly_ra = pr_rd[VW-1:0];  hd_ra = pr_rd[VW-1:0];
                if (pr_rd == UNM) begin
                    n_state = S_AG_F0;
                end else if (CW'(pr_rd) < i_nl && r_lu != FAR) begin
                    n_state = S_AG_L;
                end else begin
                    n_e = r_lnk;
                    n_state = S_AG_S;
                end
            end
            S_AG_L: begin
                if (ly_rd == r_lu + VX'(1) && r_sp < VX'(V)) begin
                    st_we = 1'b1;  st_wa = VW'(r_sp - VX'(1));  st_wd = {r_cu, r_e};
                    n_cu = r_w;  n_e = hd_rd;  n_lu = ly_rd;
                    n_sp = r_sp + VX'(1);
                end else begin
                    n_e = r_lnk;
                end
                n_state = S_AG_S;
            end
            S_AG_F0: begin
                pl_we = 1'b1;  pl_wa = r_cu;  pl_wd = VX'(r_v);
                pr_we = 1'b1;  pr_wa = r_v;   pr_wd = VX'(r_cu);
                n_k = '0;
                n_state = S_AG_F1;
            end
            S_AG_F1: begin
                st_ra = r_k[VW-1:0];
                if (r_k == r_sp - VX'(1)) begin
                    n_msize = r_msize + MW'(1);
                    if (w_last_root) begin
                        n_u = '0;  n_qh = '0;  n_qt = '0;  n_found = 1'b0;
                        n_state = S_LB_I0;
                    end else begin
                        n_u = r_u + VX'(1);
                        n_state = S_AG_I0;
                    end
                end else begin
                    n_state = S_AG_F2;
                end
            end
            S_AG_F2: begin
                n_w = st_rd[SW-1:EX];
                tg_ra = st_rd[EW-1:0];
                n_state = S_AG_F3;
            end
            S_AG_F3: begin
                pl_we = 1'b1;  pl_wa = r_w;    pl_wd = VX'(tg_rd);
                pr_we = 1'b1;  pr_wa = tg_rd;  pr_wd = VX'(r_w);
                n_k = r_k + VX'(1);
                n_state = S_AG_F1;
            end
            // alternating BFS for the cover
            S_CV_I0: begin
                pl_ra = r_u[VW-1:0];  sl_ra = GW'(r_u >> 6);
                n_state = S_CV_I1;
            end
            S_CV_I1: begin
                if (pl_rd == UNM) begin
                    sl_we = 1'b1;  sl_wa = GW'(r_u >> 6);
                    sl_wd = sl_rd | (DW'(1) << r_u[5:0]);
                    q_we = 1'b1;  q_wa = r_qt[VW-1:0];  q_wd = r_u[VW-1:0];
                    n_qt = r_qt + VX'(1);
                end
                n_u = r_u + VX'(1);
                n_state = w_last_root ? S_CV_Q : S_CV_I0;
            end
            S_CV_Q: begin
                q_ra = r_qh[VW-1:0];
                if (r_qh < r_qt) begin
                    n_qh = r_qh + VX'(1);
                    n_state = S_CV_U;
                end else begin
                    n_side = 1'b0;  n_g = '0;
                    n_state = S_OW_R;
                end
            end
            S_CV_U: begin
                hd_ra = q_rd;  pl_ra = q_rd;
                n_state = S_CV_H;
            end
            S_CV_H: begin
                n_e = hd_rd;  n_pu = pl_rd;
                n_state = S_CV_E;
            end
            S_CV_E: begin
                tg_ra = r_e[EW-1:0];  lk_ra = r_e[EW-1:0];
                n_state = (r_e >= NIL) ? S_CV_Q : S_CV_T;
            end
            S_CV_T: begin
                n_e = lk_rd;  n_v = tg_rd;
                sr_ra = GW'(tg_rd >> 6);  pr_ra = tg_rd;
                if (CW'(tg_rd) >= i_nr || r_pu == VX'(tg_rd)) begin
                    n_state = S_CV_E;
                end else begin
                    n_state = S_CV_S;
                end
            end
            S_CV_S: begin
                n_w = pr_rd[VW-1:0];
                sl_ra = GW'(pr_rd[VW-1:0] >> 6);
                if (sr_rd[r_v[5:0]]) begin
                    n_state = S_CV_E;
                end else begin
                    sr_we = 1'b1;  sr_wa = GW'(r_v >> 6);
                    sr_wd = sr_rd | (DW'(1) << r_v[5:0]);
                    n_state = (CW'(pr_rd) < i_nl) ? S_CV_L : S_CV_E;
                end
            end
            S_CV_L: begin
                if (!sl_rd[r_w[5:0]] && r_qt < VX'(V)) begin
                    sl_we = 1'b1;  sl_wa = GW'(r_w >> 6);
                    sl_wd = sl_rd | (DW'(1) << r_w[5:0]);
                    q_we = 1'b1;  q_wa = r_qt[VW-1:0];  q_wd = r_w;
                    n_qt = r_qt + VX'(1);
                end
                n_state = S_CV_E;
            end
            // cover word readout
            S_OW_R: begin
                sl_ra = GW'(r_g);  sr_ra = GW'(r_g);
                n_state = S_OW_P;
            end
            S_OW_P: begin
                sl_ra = GW'(r_g);  sr_ra = GW'(r_g);
                o_res_valid       = 1'b1;
                o_res.kind        = r_side ? bmmc_pkg::KIND_RIGHT : bmmc_pkg::KIND_LEFT;
                o_res.word_index  = bmmc_pkg::WIDX_W'(r_g);
                o_res.cover_bits  = (r_side ? sr_rd : ~sl_rd) & w_mask;
                if (i_res_ready) begin
                    if (!w_last_word) begin
                        n_g = r_g + GX'(1);
                        n_state = S_OW_R;
                    end else if (!r_side) begin
                        n_side = 1'b1;  n_g = '0;
                        n_state = S_OW_R;
                    end else begin
                        n_state = S_OS;
                    end
                end
            end
            S_OS: begin
                o_res_valid         = 1'b1;
                o_res.kind          = bmmc_pkg::KIND_SUMMARY;
                o_res.matching_size = r_msize;
                o_res.edges_dropped = r_drop;
                o_res.last          = 1'b1;
                if (i_res_ready) begin
                    n_c = '0;
                    n_state = S_CLR;
                end
            end
            default: begin
                n_c = '0;
                n_state = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_c     <= '0;
            r_total <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_c     <= n_c;
            r_total <= n_total;
            r_drop  <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u <= n_u;  r_qh <= n_qh;  r_qt <= n_qt;  r_sp <= n_sp;  r_k <= n_k;
        r_lu <= n_lu;  r_pu <= n_pu;  r_cu <= n_cu;  r_v <= n_v;  r_w <= n_w;
        r_el <= n_el;  r_e <= n_e;  r_lnk <= n_lnk;  r_id <= n_id;
        r_msize <= n_msize;  r_g <= n_g;  r_found <= n_found;
        r_last <= n_last;  r_side <= n_side;
    end

endmodule

// ===== rtl/bipartite_max_matching_cover.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bipartite_max_matching_cover
// Maximum bipartite matching (Hopcroft-Karp) with Konig minimum vertex cover.
// ----------------------------------------------------------------------------
// Usage:
//   i_edge transfers one edge (left, right, last_edge). A stored edge goes
//   through the list head/tail read, then the link write.
//   The transfer with last_edge set starts the solve; no edge is taken until
//   the solve, readout and store clear are done.
//   Solve time depends on the graph and is bounded by the single read port of
//   each state RAM.
//   o_result then carries ceil(L/64) left cover words, ceil(R/64) right words
//   and one summary (last=1).
//   The readout holds while the sink stalls; a one-entry output register
//   decouples the channel.
//   After reset and after every summary a clearing pass over all MAX_VERTICES
//   entries runs before the first edge is taken. Counts are written through
//   i_cfg_*, by the user only while idle (unchecked); reset sets both to 1024.
// ----------------------------------------------------------------------------
module bipartite_max_matching_cover #(
    parameter int MAX_VERTICES = bmmc_pkg::MAX_VERTICES,
    parameter int MAX_EDGES    = bmmc_pkg::MAX_EDGES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bmmc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bmmc_pkg::COUNT_W-1:0]   i_cfg_data,
    bmmc_edge_if.sink                      i_edge,
    bmmc_result_if.source                  o_result
);

    localparam int CW = bmmc_pkg::COUNT_W;

    logic [CW-1:0]     r_left_count, r_right_count;
    logic [CW-1:0]     nl, nr;
    bmmc_pkg::t_edge   edge_item;
    bmmc_pkg::t_result res, r_out;
    logic              res_valid, res_ready, r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_count  <= bmmc_pkg::COUNT_RESET;
            r_right_count <= bmmc_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bmmc_pkg::CFG_LEFT:  r_left_count  <= i_cfg_data;
                bmmc_pkg::CFG_RIGHT: r_right_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        nl = (r_left_count == '0) ? CW'(1) :
             (r_left_count > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : r_left_count;
        nr = (r_right_count == '0) ? CW'(1) :
             (r_right_count > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : r_right_count;
    end

    assign edge_item.edge_left  = i_edge.edge_left;
    assign edge_item.edge_right = i_edge.edge_right;
    assign edge_item.last_edge  = i_edge.last_edge;

    bmmc_engine #(.V(MAX_VERTICES), .E(MAX_EDGES)) u_engine (
        .i_clk,
        .i_rst_n,
        .i_nl         (nl),
        .i_nr         (nr),
        .i_edge       (edge_item),
        .i_edge_valid (i_edge.valid),
        .o_edge_ready (i_edge.ready),
        .o_res        (res),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready)
    );

    // output register
    assign res_ready = !r_ov || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (res_ready) begin
            r_ov <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_result.valid         = r_ov;
    assign o_result.kind          = r_out.kind;
    assign o_result.word_index    = r_out.word_index;
    assign o_result.cover_bits    = r_out.cover_bits;
    assign o_result.matching_size = r_out.matching_size;
    assign o_result.edges_dropped = r_out.edges_dropped;
    assign o_result.last          = r_out.last;

endmodule

// ===== dv/bipartite_max_matching_cover_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bipartite_max_matching_cover_test
// Streams bipartite graphs edge by edge into the matching block and checks
// each cover word and summary against an in-bench Hopcroft-Karp solver with
// Konig cover extraction. Both channels idle at random. Directed graphs cover
// the field extremes, count clamping, dropped edges and counts lowered before
// the solve. Random graphs follow.
// ----------------------------------------------------------------------------
module bipartite_max_matching_cover_test;
    import bmmc_pkg::*;

    localparam int NIL_LINK = MAX_EDGES;
    localparam int FREE     = MAX_VERTICES;
    localparam int FAR      = 32'hFFFF;
    localparam int SETTLE   = 1100;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_LEFT;
    logic [COUNT_W-1:0] i_cfg_data = '0;

    bmmc_edge_if   edge_ch ();
    bmmc_result_if res_ch ();

    bipartite_max_matching_cover dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_edge     (edge_ch),
        .o_result   (res_ch)
    );

    always #4 i_clk = ~i_clk;

    // solver state
    logic [COUNT_W-1:0] left_reg, right_reg;
    int  edge_tgt [MAX_EDGES];
    int  edge_nxt [MAX_EDGES];
    int  head [MAX_VERTICES];
    int  tail [MAX_VERTICES];
    int  n_edges;
    bit  dropped;
    int  mate_l [MAX_VERTICES];
    int  mate_r [MAX_VERTICES];
    int  layer_of [MAX_VERTICES];
    bit  reach_l [MAX_VERTICES];
    bit  reach_r [MAX_VERTICES];
    int  bfs_q [MAX_VERTICES];
    int  stk_v [MAX_VERTICES];
    int  stk_e [MAX_VERTICES];

    t_result cover_words_due[$];
    bit      failed = 1'b0;
    int      items_sent = 0;
    bit      rx_steady = 1'b0;

    function automatic int clamp_count(logic [COUNT_W-1:0] r);
        if (r == 0) return 1;
        if (r > MAX_VERTICES) return MAX_VERTICES;
        return int'(r);
    endfunction

    function automatic void clear_graph();
        for (int i = 0; i < MAX_VERTICES; i++) begin
            head[i] = NIL_LINK;
            mate_l[i] = FREE;
            mate_r[i] = FREE;
            reach_l[i] = 1'b0;
            reach_r[i] = 1'b0;
        end
        n_edges = 0;
        dropped = 1'b0;
    endfunction

    function automatic bit layer_pass(int nl, int nr);
        int qh, qt, u, v, w;
        bit found;
        qh = 0;
        qt = 0;
        found = 1'b0;
        for (u = 0; u < nl; u++) begin
            if (mate_l[u] == FREE) begin
                layer_of[u] = 0;
                bfs_q[qt++] = u;
            end else begin
                layer_of[u] = FAR;
            end
        end
        while (qh < qt) begin
            u = bfs_q[qh++];
            for (int e = head[u]; e < MAX_EDGES; e = edge_nxt[e]) begin
                v = edge_tgt[e];
                if (v >= nr) continue;
                w = mate_r[v];
                if (w == FREE) begin
                    found = 1'b1;
                end else if (w < nl && layer_of[w] == FAR && qt < MAX_VERTICES) begin
                    layer_of[w] = layer_of[u] + 1;
                    bfs_q[qt++] = w;
                end
            end
        end
        return found;
    endfunction

    function automatic bit augment_from(int root, int nl, int nr);
        int sp, u, e, v, w;
        sp = 1;
        stk_v[0] = root;
        stk_e[0] = head[root];
        while (sp > 0) begin
            u = stk_v[sp-1];
            e = stk_e[sp-1];
            if (e >= MAX_EDGES) begin
                layer_of[u] = FAR;
                sp--;
                if (sp > 0) stk_e[sp-1] = edge_nxt[stk_e[sp-1]];
                continue;
            end
            v = edge_tgt[e];
            if (v < nr) begin
                w = mate_r[v];
                if (w == FREE) begin
                    for (int k = 0; k < sp; k++) begin
                        mate_l[stk_v[k]] = edge_tgt[stk_e[k]];
                        mate_r[edge_tgt[stk_e[k]]] = stk_v[k];
                    end
                    return 1'b1;
                end
                if (w < nl && layer_of[u] != FAR && layer_of[w] == layer_of[u] + 1
                        && sp < MAX_VERTICES) begin
                    stk_v[sp] = w;
                    stk_e[sp] = head[w];
                    sp++;
                    continue;
                end
            end
            stk_e[sp-1] = edge_nxt[e];
        end
        return 1'b0;
    endfunction

    function automatic void cover_pass(int nl, int nr);
        int qh, qt, u, v, w;
        qh = 0;
        qt = 0;
        for (u = 0; u < MAX_VERTICES; u++) begin
            reach_l[u] = 1'b0;
            reach_r[u] = 1'b0;
        end
        for (u = 0; u < nl; u++)
            if (mate_l[u] == FREE) begin
                reach_l[u] = 1'b1;
                bfs_q[qt++] = u;
            end
        while (qh < qt) begin
            u = bfs_q[qh++];
            for (int e = head[u]; e < MAX_EDGES; e = edge_nxt[e]) begin
                v = edge_tgt[e];
                if (v >= nr || mate_l[u] == v || reach_r[v]) continue;
                reach_r[v] = 1'b1;
                w = mate_r[v];
                if (w < nl && !reach_l[w] && qt < MAX_VERTICES) begin
                    reach_l[w] = 1'b1;
                    bfs_q[qt++] = w;
                end
            end
        end
    endfunction

    function automatic void solve_matching(int el, int er, bit fin);
        int nl, nr, msize, cnt, id;
        logic [BITS_W-1:0] bits;
        t_result r;
        nl = clamp_count(left_reg);
        nr = clamp_count(right_reg);
        msize = 0;
        if (el >= nl || er >= nr || n_edges >= MAX_EDGES) begin
            dropped = 1'b1;
        end else begin
            id = n_edges++;
            edge_tgt[id] = er;
            edge_nxt[id] = NIL_LINK;
            if (head[el] >= MAX_EDGES) head[el] = id;
            else edge_nxt[tail[el]] = id;
            tail[el] = id;
        end
        if (!fin) return;
        while (layer_pass(nl, nr))
            for (int u = 0; u < nl; u++)
                if (mate_l[u] == FREE && augment_from(u, nl, nr)) msize++;
        cover_pass(nl, nr);
        for (int side = 0; side < 2; side++) begin
            cnt = side ? nr : nl;
            for (int g = 0; g < (cnt + 63) / 64; g++) begin
                bits = '0;
                for (int b = 0; b < GROUP && g * GROUP + b < cnt; b++)
                    bits[b] = side ? reach_r[g*GROUP+b] : !reach_l[g*GROUP+b];
                r.kind = side ? KIND_RIGHT : KIND_LEFT;
                r.word_index = g[WIDX_W-1:0];
                r.cover_bits = bits;
                r.matching_size = '0;
                r.edges_dropped = 1'b0;
                r.last = 1'b0;
                cover_words_due.insert(cover_words_due.size(), r);
            end
        end
        r.kind = KIND_SUMMARY;
        r.word_index = '0;
        r.cover_bits = '0;
        r.matching_size = msize[MSIZE_W-1:0];
        r.edges_dropped = dropped;
        r.last = 1'b1;
        cover_words_due.insert(cover_words_due.size(), r);
        clear_graph();
    endfunction

    // ---------------------------------------------------------------- drive
    task automatic send_edge(int el, int er, bit fin, bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            edge_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        edge_ch.valid <= 1'b1;
        edge_ch.edge_left <= el[EDGE_W-1:0];
        edge_ch.edge_right <= er[EDGE_W-1:0];
        edge_ch.last_edge <= fin;
        do @(posedge i_clk); while (!edge_ch.ready);
        solve_matching(el, er, fin);
        items_sent++;
    endtask

    // valid stays high after a transfer until the next send or this call
    task automatic settle();
        edge_ch.valid <= 1'b0;
        while (cover_words_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_counts(int l, int r);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_LEFT;
        i_cfg_data <= l[COUNT_W-1:0];
        @(posedge i_clk);
        i_cfg_idx <= CFG_RIGHT;
        i_cfg_data <= r[COUNT_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        left_reg = l[COUNT_W-1:0];
        right_reg = r[COUNT_W-1:0];
    endtask

    // ------------------------------------------------------------- receive
    initial begin
        int stall;
        t_result want;
        res_ch.ready <= 1'b0;
        forever begin
            if ($urandom_range(0, 31) == 0) rx_steady = !rx_steady;
            stall = rx_steady ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && i_rst_n));
            if (cover_words_due.size() == 0) begin
                $error("result transfer with nothing expected");
                failed = 1'b1;
            end else begin
                want = cover_words_due.pop_front();
                if (res_ch.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, res_ch.kind);
                    failed = 1'b1;
                end
                if (res_ch.word_index !== want.word_index) begin
                    $error("word_index: expected %0d, got %0d",
                           want.word_index, res_ch.word_index);
                    failed = 1'b1;
                end
                if (res_ch.cover_bits !== want.cover_bits) begin
                    $error("cover_bits: expected %h, got %h",
                           want.cover_bits, res_ch.cover_bits);
                    failed = 1'b1;
                end
                if (res_ch.matching_size !== want.matching_size) begin
                    $error("matching_size: expected %0d, got %0d",
                           want.matching_size, res_ch.matching_size);
                    failed = 1'b1;
                end
                if (res_ch.edges_dropped !== want.edges_dropped) begin
                    $error("edges_dropped: expected %0d, got %0d",
                           want.edges_dropped, res_ch.edges_dropped);
                    failed = 1'b1;
                end
                if (res_ch.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, res_ch.last);
                    failed = 1'b1;
                end
            end
        end
    end

    // --------------------------------------------------------------- tests
    task automatic test_field_extremes();
        send_edge(0, 0, 1'b0);
        send_edge(1023, 1023, 1'b0);
        send_edge(0, 1023, 1'b0);
        send_edge(1023, 0, 1'b0);
        send_edge(512, 512, 1'b0);
        send_edge(512, 512, 1'b0);
        send_edge(341, 682, 1'b1);
    endtask

    task automatic test_count_clamp();
        set_counts(0, 2047);
        send_edge(0, 5, 1'b0);
        send_edge(1, 1, 1'b0);
        send_edge(0, 1023, 1'b1);
        set_counts(2047, 0);
        send_edge(700, 0, 1'b0);
        send_edge(5, 1, 1'b1);
    endtask

    task automatic test_dropped_last();
        set_counts(8, 8);
        send_edge(1, 1, 1'b0);
        send_edge(2, 1, 1'b0);
        send_edge(9, 0, 1'b1);
    endtask

    task automatic test_counts_lowered();
        set_counts(64, 64);
        send_edge(3, 40, 1'b0);
        send_edge(10, 60, 1'b0);
        send_edge(3, 10, 1'b0);
        send_edge(1, 10, 1'b0);
        set_counts(5, 30);
        send_edge(2, 2, 1'b1);
    endtask

    task automatic test_random_graphs();
        int nl, nr, len, el, er;
        while (items_sent < 480) begin
            if ($urandom_range(0, 5) == 0) begin
                set_counts($urandom_range(0, 2047), $urandom_range(0, 2047));
            end else begin
                set_counts($urandom_range(1, 128), $urandom_range(1, 128));
            end
            nl = clamp_count(left_reg);
            nr = clamp_count(right_reg);
            len = $urandom_range(1, 24);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    el = $urandom_range(0, 1023);
                    er = $urandom_range(0, 1023);
                end else begin
                    el = $urandom_range(0, nl - 1);
                    er = $urandom_range(0, nr - 1);
                end
                send_edge(el, er, i == len - 1);
            end
        end
    endtask

    initial begin
        edge_ch.valid <= 1'b0;
        edge_ch.edge_left <= '0;
        edge_ch.edge_right <= '0;
        edge_ch.last_edge <= 1'b0;
        left_reg = COUNT_RESET;
        right_reg = COUNT_RESET;
        clear_graph();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_field_extremes();
        test_count_clamp();
        test_dropped_last();
        test_counts_lowered();
        test_random_graphs();
        settle();
        if (!failed) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
